FILE: sv/kbd_pkg.sv
// Shared types, codes and key tables for the scan code to ASCII decoder.
`timescale 1ns / 1ps
`default_nettype none
package kbd_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int FILL_MAX       = 255;

  // request kinds
  localparam logic [1:0] KIND_SCAN  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // result outcomes
  localparam logic [2:0] OUT_NONE      = 3'd0;
  localparam logic [2:0] OUT_QUEUED    = 3'd1;
  localparam logic [2:0] OUT_DROPPED   = 3'd2;
  localparam logic [2:0] OUT_DELIVERED = 3'd3;
  localparam logic [2:0] OUT_EMPTY     = 3'd4;
  localparam logic [2:0] OUT_FLUSHED   = 3'd5;

  // scan codes (set 1, make codes)
  localparam logic [7:0] RELEASE_BIT = 8'h80;
  localparam logic [6:0] KEY_MASK    = 7'h7F;
  localparam logic [6:0] KEY_ENTER   = 7'h1C;
  localparam logic [6:0] KEY_BKSP    = 7'h0E;
  localparam logic [6:0] KEY_TAB     = 7'h0F;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_ALT     = 7'h38;
  localparam logic [6:0] KEY_CAPS    = 7'h3A;

  localparam logic [6:0] CHR_LF = 7'h0A;
  localparam logic [6:0] CHR_BS = 7'h08;
  localparam logic [6:0] CHR_HT = 7'h09;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] scan_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [6:0] char_out;
    logic [7:0] fill_level;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } mods_t;

  typedef struct packed {
    mods_t      mods;  // modifier state after the byte
    logic [6:0] ch;    // character to queue, zero for none or release
  } dec_t;

  function automatic logic [6:0] lower_char(input logic [6:0] key);
    logic [6:0] c;
    case (key)
      7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
      7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
      7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D; 7'h0D: c = 7'h3D;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1E: c = 7'h61; 7'h1F: c = 7'h73; 7'h20: c = 7'h64; 7'h21: c = 7'h66;
      7'h22: c = 7'h67; 7'h23: c = 7'h68; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B;
      7'h26: c = 7'h6C; 7'h27: c = 7'h3B; 7'h28: c = 7'h27; 7'h29: c = 7'h60;
      7'h2B: c = 7'h5C; 7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63;
      7'h2F: c = 7'h76; 7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D;
      7'h33: c = 7'h2C; 7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // shifted table: no space and no keypad star
  function automatic logic [6:0] upper_char(input logic [6:0] key);
    logic [6:0] c;
    case (key)
      7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
      7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26; 7'h09: c = 7'h2A;
      7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F; 7'h0D: c = 7'h2B;
      7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
      7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
      7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
      7'h1E: c = 7'h41; 7'h1F: c = 7'h53; 7'h20: c = 7'h44; 7'h21: c = 7'h46;
      7'h22: c = 7'h47; 7'h23: c = 7'h48; 7'h24: c = 7'h4A; 7'h25: c = 7'h4B;
      7'h26: c = 7'h4C; 7'h27: c = 7'h3A; 7'h28: c = 7'h22; 7'h29: c = 7'h7E;
      7'h2B: c = 7'h7C; 7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43;
      7'h2F: c = 7'h56; 7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D;
      7'h33: c = 7'h3C; 7'h34: c = 7'h3E; 7'h35: c = 7'h3F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/kbd_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module kbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/kbd_decode.sv
// Scan code byte decode: modifier tracking and character lookup.
`timescale 1ns / 1ps
`default_nettype none
module kbd_decode (
  input  wire logic [7:0]     scan_byte,
  input  wire kbd_pkg::mods_t mods_cur,
  output kbd_pkg::dec_t       dec
);

  logic       down;
  logic [6:0] key;
  logic       upper;
  logic [6:0] look;

  always_comb begin
    down     = (scan_byte & kbd_pkg::RELEASE_BIT) == 8'h00;
    key      = scan_byte[6:0] & kbd_pkg::KEY_MASK;
    dec.mods = mods_cur;
    unique case (key) inside
      kbd_pkg::KEY_LSHIFT, kbd_pkg::KEY_RSHIFT: dec.mods.shift = down;
      kbd_pkg::KEY_CTRL:                        dec.mods.ctrl  = down;
      kbd_pkg::KEY_ALT:                         dec.mods.alt   = down;
      kbd_pkg::KEY_CAPS:                        dec.mods.caps  = mods_cur.caps ^ down;
      default: ;
    endcase

    // table choice uses the state after this byte
    upper = dec.mods.shift ^ dec.mods.caps;
    look  = upper ? kbd_pkg::upper_char(key) : kbd_pkg::lower_char(key);

    if (!down) begin
      dec.ch = 7'h00;
    end else if (key == kbd_pkg::KEY_ENTER) begin
      dec.ch = kbd_pkg::CHR_LF;
    end else if (key == kbd_pkg::KEY_BKSP) begin
      dec.ch = kbd_pkg::CHR_BS;
    end else if (key == kbd_pkg::KEY_TAB) begin
      dec.ch = kbd_pkg::CHR_HT;
    end else begin
      dec.ch = look;
    end
  end

endmodule
`default_nettype wire

FILE: sv/keyboard_scancode_to_ascii_fifo.sv
// Scan code set 1 keyboard decoder with a character ring buffer.
//
// Input channel (in_valid/in_ready/in_data) carries one request word: a
// scan code byte, a pop of one character, or a flush of the ring. Every
// request yields exactly one result word on out_valid/out_ready/out_data
// with the outcome, the popped character, the ring fill level and the
// modifier state after the request.
// The result passes the middle stage, where the ring read completes, and then
// the output register. Throughput: one word per cycle unless out_ready stalls.
// Decode, index update and the single ring access all happen in the accept
// cycle; the ring is a one-write one-read RAM with registered read, so a pop's
// character arrives in the next cycle.
// A pop always reads an entry written at an earlier edge, so no bypass.
// Reset (rst_n low, synchronous) empties the ring and clears all modifiers;
// ring contents are not cleared, only the indices.
// When out_ready is low the output register holds and one more word can be
// taken into the middle stage; after that in_ready drops until out drains.
`timescale 1ns / 1ps
`default_nettype none
module keyboard_scancode_to_ascii_fifo #(
  parameter int RING_DEPTH = kbd_pkg::RING_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire kbd_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output kbd_pkg::out_word_t      out_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int FW    = (CNT_W > 8) ? CNT_W : 8;

  logic [IDX_W-1:0]   w_idx_r, w_idx_nxt;
  logic [IDX_W-1:0]   r_idx_r, r_idx_nxt;
  kbd_pkg::mods_t     mods_r, mods_nxt;

  logic               p_valid_r, p_valid_nxt;
  logic               p_deliv_r, p_deliv_nxt;
  kbd_pkg::out_word_t p_word_r, p_word_nxt;

  logic               out_valid_r, out_valid_nxt;
  kbd_pkg::out_word_t out_word_r, out_word_nxt;

  kbd_pkg::dec_t      dec;
  logic               acc;
  logic               p_move;
  logic               ram_we, ram_re;
  logic [6:0]         ram_rdata;
  logic [IDX_W-1:0]   w_inc, r_inc;
  logic [CNT_W-1:0]   occ;
  logic [FW-1:0]      occ_w;
  logic [2:0]         outcome;

  kbd_decode u_dec (
    .scan_byte (in_data.scan_byte),
    .mods_cur  (mods_r),
    .dec       (dec)
  );

  kbd_ram #(
    .WIDTH (7),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_idx_r),
    .wdata (dec.ch),
    .re    (ram_re),
    .raddr (r_idx_r),
    .rdata (ram_rdata)
  );

  assign p_move    = !out_valid_r || out_ready;
  assign in_ready  = !p_valid_r || p_move;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign w_inc = (w_idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : w_idx_r + 1'b1;
  assign r_inc = (r_idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : r_idx_r + 1'b1;

  always_comb begin
    w_idx_nxt = w_idx_r;
    r_idx_nxt = r_idx_r;
    mods_nxt  = mods_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    outcome   = kbd_pkg::OUT_NONE;
    unique case (in_data.kind)
      kbd_pkg::KIND_SCAN: begin
        mods_nxt = dec.mods;
        if (dec.ch != 7'h00) begin
          if (w_inc == r_idx_r) begin
            outcome = kbd_pkg::OUT_DROPPED;
          end else begin
            outcome   = kbd_pkg::OUT_QUEUED;
            ram_we    = acc;
            w_idx_nxt = w_inc;
          end
        end
      end
      kbd_pkg::KIND_POP: begin
        if (r_idx_r == w_idx_r) begin
          outcome = kbd_pkg::OUT_EMPTY;
        end else begin
          outcome   = kbd_pkg::OUT_DELIVERED;
          ram_re    = acc;
          r_idx_nxt = r_inc;
        end
      end
      kbd_pkg::KIND_FLUSH: begin
        outcome   = kbd_pkg::OUT_FLUSHED;
        w_idx_nxt = '0;
        r_idx_nxt = '0;
      end
      default: ;
    endcase

    if (w_idx_nxt >= r_idx_nxt) begin
      occ = {1'b0, w_idx_nxt} - {1'b0, r_idx_nxt};
    end else begin
      occ = {1'b0, w_idx_nxt} + CNT_W'(RING_DEPTH) - {1'b0, r_idx_nxt};
    end
    occ_w = FW'(occ);

    p_word_nxt.outcome    = outcome;
    p_word_nxt.char_out   = 7'h00;
    p_word_nxt.fill_level = (occ_w > FW'(kbd_pkg::FILL_MAX)) ? 8'hFF : occ_w[7:0];
    p_word_nxt.shift_held = mods_nxt.shift;
    p_word_nxt.ctrl_held  = mods_nxt.ctrl;
    p_word_nxt.alt_held   = mods_nxt.alt;
    p_word_nxt.caps_on    = mods_nxt.caps;
    p_deliv_nxt           = (outcome == kbd_pkg::OUT_DELIVERED);
    p_valid_nxt           = acc ? 1'b1 : (p_valid_r && !p_move);

    out_valid_nxt = p_move ? p_valid_r : out_valid_r;
    out_word_nxt  = out_word_r;
    if (p_move && p_valid_r) begin
      out_word_nxt          = p_word_r;
      out_word_nxt.char_out = p_deliv_r ? ram_rdata : 7'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_idx_r     <= '0;
      r_idx_r     <= '0;
      mods_r      <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        w_idx_r <= w_idx_nxt;
        r_idx_r <= r_idx_nxt;
        mods_r  <= mods_nxt;
      end
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_word_r  <= p_word_nxt;
      p_deliv_r <= p_deliv_nxt;
    end
    out_word_r <= out_word_nxt;
  end

`ifndef ASSERT_OFF
  // ring read data must not be overwritten while a popped word waits in the middle stage
  a_no_read_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && !p_move) |-> !ram_re)
    else $error("ring read issued while middle stage is stalled");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.kind == kbd_pkg::KIND_FLUSH) |=> (w_idx_r == '0 && r_idx_r == '0))
    else $error("flush did not clear ring indices");

  a_char_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.outcome != kbd_pkg::OUT_DELIVERED)
      |-> (out_word_r.char_out == 7'h00))
    else $error("character present on a non-pop result");

  a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("ring written and read by the same word");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (FW'(out_word_r.fill_level) <= FW'(RING_DEPTH - 1)))
    else $error("fill level beyond ring capacity");
`endif

endmodule
`default_nettype wire
